FILE: rtl/core/pnce_pkg.sv
// Shared types, widths and register codes for the periodic neighbour cell enumerator.
// No dependencies; every other file in rtl/core refers to this package by scoped name.
`default_nettype none

package pnce_pkg;

  localparam int unsigned MaxCellsPerAxis = 256;
  localparam int unsigned MaxRadius       = 1;

  localparam int unsigned NumAxes  = 3;
  localparam int unsigned PosW     = 32;
  localparam int unsigned SizeW    = 32;
  localparam int unsigned CellW    = $clog2(MaxCellsPerAxis);      // home / cell coordinate
  localparam int unsigned CntW     = 9;                            // cells_* register width
  localparam int unsigned NxnyW    = 2 * CellW + 1;                // nx*ny up to 2^(2*CellW)
  localparam int unsigned IdxW     = 24;
  localparam int unsigned WrapW    = 2;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned QDepth   = 2;
  localparam int unsigned QPtrW    = $clog2(QDepth);
  localparam int unsigned QCntW    = QPtrW + 1;
  localparam int unsigned StepW    = $clog2(CellW);

  localparam int unsigned InDataW  = 3 * PosW;
  localparam int unsigned OutDataW = ((IdxW + 3 * WrapW + 7) / 8) * 8;
  localparam int unsigned OutPadW  = OutDataW - IdxW - 3 * WrapW;

  typedef enum logic [CfgIdxW-1:0] {
    RegPeriodic  = 3'd0,
    RegCellsX    = 3'd1,
    RegCellsY    = 3'd2,
    RegCellsZ    = 3'd3,
    RegRadius    = 3'd4,
    RegSizeX     = 3'd5,
    RegSizeY     = 3'd6,
    RegSizeZ     = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    FrontIdle,
    FrontDiv,
    FrontPush
  } front_state_e;

  // Effective configuration seen by the front and back parts.
  typedef struct packed {
    logic                             periodic;
    logic                             radius;
    logic [NumAxes-1:0][SizeW-1:0]    size;
    logic [NumAxes-1:0][CellW-1:0]    last_cell;   // effective cells - 1
    logic [CntW-1:0]                  nx;
    logic [NxnyW-1:0]                 nxny;
  } cfg_t;

  // One queued position: home cell per axis, x in the lowest slot.
  typedef struct packed {
    logic [NumAxes-1:0][CellW-1:0] home;
  } home_t;

endpackage

`default_nettype wire

FILE: rtl/core/pnce_queue.sv
// Two-entry FIFO of home cells between the divider front and the enumerating back.
// Depends on pnce_pkg.
`default_nettype none

module pnce_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  pnce_pkg::home_t    push_data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output pnce_pkg::home_t    head_o,
  output logic               empty_o
);

  pnce_pkg::home_t                    mem_q [pnce_pkg::QDepth];
  logic [pnce_pkg::QPtrW-1:0]         wr_ptr_q, wr_ptr_d;
  logic [pnce_pkg::QPtrW-1:0]         rd_ptr_q, rd_ptr_d;
  logic [pnce_pkg::QCntW-1:0]         count_q, count_d;

  localparam logic [pnce_pkg::QCntW-1:0] Full = pnce_pkg::QCntW'(pnce_pkg::QDepth);
  localparam logic [pnce_pkg::QPtrW-1:0] LastSlot = pnce_pkg::QPtrW'(pnce_pkg::QDepth - 1);

  assign full_o  = (count_q == Full);
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastSlot) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastSlot) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o || pop_i)
    else $error("queue overflow");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue underflow");

endmodule

`default_nettype wire

FILE: rtl/core/pnce_front.sv
// Front part: takes a position beat and derives the saturated home cell per axis
// with three radix-2 quotient units, then hands it to the queue. Depends on pnce_pkg.
`default_nettype none

module pnce_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  pnce_pkg::cfg_t                     cfg_i,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [pnce_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                               push_o,
  output pnce_pkg::home_t                    push_data_o,
  input  wire logic                          full_i
);

  localparam int unsigned N  = pnce_pkg::NumAxes;
  localparam int unsigned CW = pnce_pkg::CellW;
  localparam int unsigned SW = pnce_pkg::SizeW;
  localparam int unsigned PW = pnce_pkg::PosW;
  localparam int unsigned HiW = PW - CW;   // position bits above the quotient window
  localparam logic [pnce_pkg::StepW-1:0] LastStep = pnce_pkg::StepW'(CW - 1);

  pnce_pkg::front_state_e state_q, state_d;
  logic [pnce_pkg::StepW-1:0] step_q, step_d;
  logic                        accept;

  logic [SW-1:0] rem_q  [N];
  logic [CW-1:0] low_q  [N];
  logic [CW-1:0] quot_q [N];
  logic          sat_q  [N];

  logic [PW-1:0] pos     [N];
  logic [SW:0]   trial   [N];
  logic [SW:0]   diff    [N];
  logic          fits    [N];

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pnce_pkg::FrontIdle: begin
        if (s_axis_tvalid) state_d = pnce_pkg::FrontDiv;
      end
      pnce_pkg::FrontDiv: begin
        if (step_q == LastStep) state_d = pnce_pkg::FrontPush;
      end
      pnce_pkg::FrontPush: begin
        if (!full_i) state_d = pnce_pkg::FrontIdle;
      end
      default: state_d = pnce_pkg::FrontIdle;
    endcase
  end

  // Outputs
  always_comb begin
    s_axis_tready = 1'b0;
    push_o        = 1'b0;
    unique case (state_q)
      pnce_pkg::FrontIdle: s_axis_tready = 1'b1;
      pnce_pkg::FrontDiv:  s_axis_tready = 1'b0;
      pnce_pkg::FrontPush: push_o        = !full_i;
      default: begin
        s_axis_tready = 1'b0;
        push_o        = 1'b0;
      end
    endcase
  end

  assign accept = s_axis_tvalid && s_axis_tready;
  assign step_d = (state_q == pnce_pkg::FrontDiv) ? step_q + 1'b1 : '0;

  // One quotient bit per axis per cycle; quotients of 2^CW or more saturate up front.
  always_comb begin
    for (int a = 0; a < N; a++) begin
      pos[a]   = s_axis_tdata[a*PW +: PW];
      trial[a] = {rem_q[a], low_q[a][CW-1]};
      diff[a]  = trial[a] - {1'b0, cfg_i.size[a]};
      fits[a]  = (trial[a] >= {1'b0, cfg_i.size[a]});
    end
  end

  always_comb begin
    for (int a = 0; a < N; a++) begin
      if (sat_q[a] || (quot_q[a] > cfg_i.last_cell[a])) begin
        push_data_o.home[a] = cfg_i.last_cell[a];
      end else begin
        push_data_o.home[a] = quot_q[a];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pnce_pkg::FrontIdle;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < N; a++) begin
      if (accept) begin
        rem_q[a]  <= SW'(pos[a][PW-1:CW]);
        low_q[a]  <= pos[a][CW-1:0];
        quot_q[a] <= '0;
        sat_q[a]  <= (SW'(pos[a][PW-1:CW]) >= cfg_i.size[a]);
      end else if (state_q == pnce_pkg::FrontDiv) begin
        rem_q[a]  <= fits[a] ? diff[a][SW-1:0] : trial[a][SW-1:0];
        low_q[a]  <= {low_q[a][CW-2:0], 1'b0};
        quot_q[a] <= {quot_q[a][CW-2:0], fits[a]};
      end
    end
  end

  // HiW documents the window split; the upper slice must be non-empty.
  a_push_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (HiW > 0) && (state_q == pnce_pkg::FrontPush) && !full_i)
    else $error("push outside hand-off state");

endmodule

`default_nettype wire

FILE: rtl/core/pnce_back.sv
// Back part: walks the neighbour cells of one queued home cell, x outer, z inner, one
// beat per cycle unless stalled, into a registered output stage. Depends on pnce_pkg.
`default_nettype none

module pnce_back (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  pnce_pkg::cfg_t                      cfg_i,
  input  pnce_pkg::home_t                     head_i,
  input  wire logic                           empty_i,
  output logic                                pop_o,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic [pnce_pkg::OutDataW-1:0]       m_axis_tdata,
  output logic                                m_axis_tlast
);

  localparam int unsigned N  = pnce_pkg::NumAxes;
  localparam int unsigned CW = pnce_pkg::CellW;
  localparam int unsigned WW = pnce_pkg::WrapW;
  localparam int unsigned PxW = pnce_pkg::CntW + CW;
  localparam int unsigned PzW = pnce_pkg::NxnyW + CW;

  localparam logic signed [WW-1:0] OffMinus = -2'sd1;
  localparam logic signed [WW-1:0] OffZero  = 2'sd0;
  localparam logic signed [WW-1:0] OffPlus  = 2'sd1;

  typedef struct packed {
    logic [CW-1:0] coord;
    logic [WW-1:0] wrap;
  } axis_map_t;

  function automatic axis_map_t map_axis(logic [CW-1:0] home, logic signed [WW-1:0] off,
                                         logic [CW-1:0] last);
    axis_map_t m;
    m.wrap  = OffZero;
    m.coord = CW'(home + {{(CW-WW){off[WW-1]}}, off});
    if (off == OffPlus && home == last) begin
      m.coord = '0;
      m.wrap  = OffPlus;
    end else if (off == OffMinus && home == '0) begin
      m.coord = last;
      m.wrap  = OffMinus;
    end
    return m;
  endfunction

  logic                        busy_q, busy_d;
  logic [CW-1:0]               home_q [N];
  logic signed [WW-1:0]        off_q  [N];
  logic signed [WW-1:0]        lo_q   [N];
  logic signed [WW-1:0]        hi_q   [N];
  logic signed [WW-1:0]        lo_new [N];
  logic signed [WW-1:0]        hi_new [N];
  logic signed [WW-1:0]        off_d  [N];
  logic signed [WW-1:0]        reach;
  axis_map_t                   map    [N];
  logic                        at_hi  [N];
  logic                        last_beat;
  logic                        advance;

  logic [PxW-1:0]              prod_y;
  logic [PzW-1:0]              prod_z;
  logic [PzW-1:0]              index_sum;

  logic                        out_valid_q, out_valid_d;
  logic [pnce_pkg::IdxW-1:0]   out_index_q;
  logic [WW-1:0]               out_wrap_q [N];
  logic                        out_last_q;

  assign reach   = cfg_i.radius ? OffPlus : OffZero;
  assign pop_o   = !busy_q && !empty_i;
  assign advance = busy_q && (!out_valid_q || m_axis_tready);

  // Offset range per axis; open mode clips at the grid faces.
  always_comb begin
    for (int a = 0; a < N; a++) begin
      lo_new[a] = (!cfg_i.periodic && head_i.home[a] == '0) ? OffZero : -reach;
      hi_new[a] = (!cfg_i.periodic && head_i.home[a] == cfg_i.last_cell[a]) ? OffZero : reach;
      map[a]    = map_axis(home_q[a], off_q[a], cfg_i.last_cell[a]);
      at_hi[a]  = (off_q[a] == hi_q[a]);
    end
  end

  assign last_beat = at_hi[0] && at_hi[1] && at_hi[2];

  // Odometer over the three offsets, z fastest.
  always_comb begin
    for (int a = 0; a < N; a++) begin
      off_d[a] = off_q[a];
    end
    if (!at_hi[2]) begin
      off_d[2] = off_q[2] + OffPlus;
    end else begin
      off_d[2] = lo_q[2];
      if (!at_hi[1]) begin
        off_d[1] = off_q[1] + OffPlus;
      end else begin
        off_d[1] = lo_q[1];
        off_d[0] = off_q[0] + OffPlus;
      end
    end
  end

  assign prod_y    = PxW'(cfg_i.nx) * PxW'(map[1].coord);
  assign prod_z    = PzW'(cfg_i.nxny) * PzW'(map[2].coord);
  assign index_sum = PzW'(map[0].coord) + PzW'(prod_y) + prod_z;

  always_comb begin
    busy_d = busy_q;
    if (pop_o) begin
      busy_d = 1'b1;
    end else if (advance && last_beat) begin
      busy_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < N; a++) begin
      if (pop_o) begin
        home_q[a] <= head_i.home[a];
        lo_q[a]   <= lo_new[a];
        hi_q[a]   <= hi_new[a];
        off_q[a]  <= lo_new[a];
      end else if (advance) begin
        off_q[a]  <= off_d[a];
      end
      if (advance) begin
        out_wrap_q[a] <= map[a].wrap;
      end
    end
    if (advance) begin
      out_index_q <= index_sum[pnce_pkg::IdxW-1:0];
      out_last_q  <= last_beat;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {{pnce_pkg::OutPadW{1'b0}}, out_wrap_q[2], out_wrap_q[1], out_wrap_q[0],
                          out_index_q};

  a_done_with_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> out_valid_q && out_last_q)
    else $error("position finished without a last beat");

endmodule

`default_nettype wire

FILE: rtl/core/periodic_neighbour_cell_enumerator_top.sv
// Top level of the periodic neighbour cell enumerator: configuration registers,
// front (home cell divider), queue and back (neighbour walk). Depends on pnce_pkg,
// pnce_front, pnce_queue and pnce_back.
//
//  channel   dir  handshake                   payload
//  --------  ---  --------------------------  ---------------------------------------------
//  s_axis    in   s_axis_tvalid/tready        tdata: pos_x[31:0] pos_y[63:32] pos_z[95:64]
//  m_axis    out  m_axis_tvalid/tready        tdata: cell_index, wrap_x, wrap_y, wrap_z;
//                                             tlast: last_cell
//  cfg       in   cfg_valid_i/cfg_ready_o     cfg_index_i register, cfg_data_i value
//
//  Front: each position goes through accept, 8 quotient steps and hand-off, paced by its
//  one-bit-per-cycle quotient units; it takes no new position before the hand-off.
//  The back loads a home cell, then gives one beat per neighbour cell (1 to 27).
//  Reset: registers return to their defaults (periodic, 16^3 grid, radius 1, unit cells);
//  the queue and output stage come up empty.
//  Stalls: m_axis_tready low holds the output register; the front keeps dividing, parks
//  up to two home cells in the queue, then holds one more in its hand-off state with
//  s_axis_tready low until a queue slot frees.
`default_nettype none

module periodic_neighbour_cell_enumerator_top (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // position beats: {pos_z, pos_y, pos_x}, pos_x lowest
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [pnce_pkg::InDataW-1:0]    s_axis_tdata,
  // cell beats: cell_index[23:0] wrap_x[25:24] wrap_y[27:26] wrap_z[29:28] zero[31:30]
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [pnce_pkg::OutDataW-1:0]        m_axis_tdata,
  output logic                                 m_axis_tlast,
  // configuration writes
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [pnce_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [pnce_pkg::CfgDataW-1:0]   cfg_data_i
);

  localparam int unsigned CntW  = pnce_pkg::CntW;
  localparam int unsigned CW    = pnce_pkg::CellW;
  localparam logic [CntW-1:0] MaxCells = CntW'(pnce_pkg::MaxCellsPerAxis);
  localparam logic [CntW-1:0] CellsRst = CntW'(16);
  localparam logic [pnce_pkg::SizeW-1:0] SizeRst = pnce_pkg::SizeW'(65536);

  function automatic logic [CntW-1:0] eff_cells(logic [CntW-1:0] n);
    logic [CntW-1:0] e;
    e = n;
    if (n == '0) e = CntW'(1);
    else if (n > MaxCells) e = MaxCells;
    return e;
  endfunction

  logic                           periodic_q;
  logic                           radius_q;
  logic [CntW-1:0]                cells_q [pnce_pkg::NumAxes];
  logic [pnce_pkg::SizeW-1:0]     size_q  [pnce_pkg::NumAxes];
  logic [CntW-1:0]                eff     [pnce_pkg::NumAxes];
  logic [pnce_pkg::NxnyW-1:0]     nxny_q;
  logic                           cfg_we;
  pnce_pkg::cfg_t                 cfg;

  pnce_pkg::home_t                push_data;
  pnce_pkg::home_t                head;
  logic                           push, pop, full, empty;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      periodic_q <= 1'b1;
      radius_q   <= 1'b1;
      for (int a = 0; a < pnce_pkg::NumAxes; a++) begin
        cells_q[a] <= CellsRst;
        size_q[a]  <= SizeRst;
      end
    end else if (cfg_we) begin
      unique case (pnce_pkg::cfg_reg_e'(cfg_index_i))
        pnce_pkg::RegPeriodic: periodic_q <= cfg_data_i[0];
        pnce_pkg::RegCellsX:   cells_q[0] <= cfg_data_i[CntW-1:0];
        pnce_pkg::RegCellsY:   cells_q[1] <= cfg_data_i[CntW-1:0];
        pnce_pkg::RegCellsZ:   cells_q[2] <= cfg_data_i[CntW-1:0];
        pnce_pkg::RegRadius:   radius_q   <= cfg_data_i[0];
        pnce_pkg::RegSizeX:    size_q[0]  <= cfg_data_i;
        pnce_pkg::RegSizeY:    size_q[1]  <= cfg_data_i;
        pnce_pkg::RegSizeZ:    size_q[2]  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Registered z stride: user changes config only while idle (unenforced); lag harmless.
  always_ff @(posedge clk_i) begin
    nxny_q <= pnce_pkg::NxnyW'(eff[0]) * pnce_pkg::NxnyW'(eff[1]);
  end

  always_comb begin
    cfg.periodic = periodic_q;
    cfg.radius   = radius_q;
    cfg.nxny     = nxny_q;
    for (int a = 0; a < pnce_pkg::NumAxes; a++) begin
      eff[a]           = eff_cells(cells_q[a]);
      cfg.size[a]      = size_q[a];
      cfg.last_cell[a] = CW'(eff[a] - 1'b1);
    end
    cfg.nx       = eff[0];
  end

  pnce_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .push_o       (push),
    .push_data_o  (push_data),
    .full_i       (full)
  );

  pnce_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .full_o     (full),
    .pop_i      (pop),
    .head_o     (head),
    .empty_o    (empty)
  );

  pnce_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .head_i       (head),
    .empty_i      (empty),
    .pop_o        (pop),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

endmodule

`default_nettype wire

FILE: verif/pnce_cell_checker.sv
// Scoreboard for the periodic neighbour cell enumerator: watches the config, position
// and cell channels, predicts each position's cell beats and compares them. Needs pnce_pkg.
module pnce_cell_checker
  import pnce_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // pos_x, pos_y, pos_z
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [OutDataW-1:0] m_axis_tdata,   // cell_index, wrap_x, wrap_y, wrap_z, pad
  input  logic                m_axis_tlast,   // last_cell
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int                  cells_due_o,
  output int                  mismatches_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [IdxW-1:0]  index;
    logic [WrapW-1:0] wrap_x;
    logic [WrapW-1:0] wrap_y;
    logic [WrapW-1:0] wrap_z;
    logic             last;
  } cell_beat_t;

  // register mirror, axis 0 = x
  logic             periodic_q;
  logic             radius_q;
  logic [CntW-1:0]  cells_q [3];
  logic [SizeW-1:0] size_q  [3];

  cell_beat_t cell_q [$];
  int         mismatch_cnt = 0;
  cell_beat_t want;

  assign mismatches_o = mismatch_cnt;

  function automatic int axis_cells(logic [CntW-1:0] n);
    if (n == 0) return 1;
    if (n > MaxCellsPerAxis) return MaxCellsPerAxis;
    return int'(n);
  endfunction

  function automatic int home_of(logic [PosW-1:0] pos, logic [SizeW-1:0] size, int n);
    logic [31:0] q;
    q = (size == 0) ? '1 : pos / size;
    if (q > 32'(n - 1)) q = 32'(n - 1);
    return int'(q);
  endfunction

  // Walk the 3x3x3 (or single) block about the home cell, x outer, z inner; open mode clips.
  function automatic void predict_cells(logic [PosW-1:0] pos_x, logic [PosW-1:0] pos_y,
                                        logic [PosW-1:0] pos_z);
    int nx, ny, nz, rad, hx, hy, hz, vx, vy, vz, wx, wy, wz, cnt;
    cell_beat_t batch [27];
    cnt = 0;
    nx  = axis_cells(cells_q[0]);
    ny  = axis_cells(cells_q[1]);
    nz  = axis_cells(cells_q[2]);
    rad = int'(radius_q);
    hx  = home_of(pos_x, size_q[0], nx);
    hy  = home_of(pos_y, size_q[1], ny);
    hz  = home_of(pos_z, size_q[2], nz);
    for (int dx = -rad; dx <= rad; dx++) begin
      vx = hx + dx;
      wx = (vx >= nx) ? 1 : ((vx < 0) ? -1 : 0);
      if (!periodic_q && wx != 0) continue;
      vx = vx - wx * nx;
      for (int dy = -rad; dy <= rad; dy++) begin
        vy = hy + dy;
        wy = (vy >= ny) ? 1 : ((vy < 0) ? -1 : 0);
        if (!periodic_q && wy != 0) continue;
        vy = vy - wy * ny;
        for (int dz = -rad; dz <= rad; dz++) begin
          vz = hz + dz;
          wz = (vz >= nz) ? 1 : ((vz < 0) ? -1 : 0);
          if (!periodic_q && wz != 0) continue;
          vz = vz - wz * nz;
          batch[cnt].index  = IdxW'(vx + nx * vy + nx * ny * vz);
          batch[cnt].wrap_x = WrapW'(wx);
          batch[cnt].wrap_y = WrapW'(wy);
          batch[cnt].wrap_z = WrapW'(wz);
          batch[cnt].last   = 1'b0;
          cnt++;
        end
      end
    end
    for (int i = 0; i < cnt; i++) begin
      batch[i].last = (i == cnt - 1);
      cell_q.push_back(batch[i]);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      periodic_q = 1'b1;
      radius_q   = 1'b1;
      for (int a = 0; a < 3; a++) begin
        cells_q[a] = 16;
        size_q[a]  = 32'h0001_0000;
      end
      cell_q.delete();
      cells_due_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_reg_e'(cfg_index_i))
          RegPeriodic: periodic_q = cfg_data_i[0];
          RegCellsX:   cells_q[0] = cfg_data_i[CntW-1:0];
          RegCellsY:   cells_q[1] = cfg_data_i[CntW-1:0];
          RegCellsZ:   cells_q[2] = cfg_data_i[CntW-1:0];
          RegRadius:   radius_q   = cfg_data_i[0];
          RegSizeX:    size_q[0]  = cfg_data_i;
          RegSizeY:    size_q[1]  = cfg_data_i;
          RegSizeZ:    size_q[2]  = cfg_data_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        predict_cells(s_axis_tdata[PosW-1:0], s_axis_tdata[2*PosW-1:PosW],
                      s_axis_tdata[3*PosW-1:2*PosW]);
      if (m_axis_tvalid && m_axis_tready) begin
        if (cell_q.size() == 0) begin
          $error("cell beat with nothing expected: tdata %h tlast %b",
                 m_axis_tdata, m_axis_tlast);
          mismatch_cnt++;
        end else begin
          want = cell_q.pop_front();
          if (m_axis_tdata[IdxW-1:0] !== want.index) begin
            $error("cell_index expected %0d got %0d", want.index, m_axis_tdata[IdxW-1:0]);
            mismatch_cnt++;
          end
          if (m_axis_tdata[IdxW+:WrapW] !== want.wrap_x) begin
            $error("wrap_x expected %b got %b", want.wrap_x, m_axis_tdata[IdxW+:WrapW]);
            mismatch_cnt++;
          end
          if (m_axis_tdata[IdxW+WrapW+:WrapW] !== want.wrap_y) begin
            $error("wrap_y expected %b got %b", want.wrap_y,
                   m_axis_tdata[IdxW+WrapW+:WrapW]);
            mismatch_cnt++;
          end
          if (m_axis_tdata[IdxW+2*WrapW+:WrapW] !== want.wrap_z) begin
            $error("wrap_z expected %b got %b", want.wrap_z,
                   m_axis_tdata[IdxW+2*WrapW+:WrapW]);
            mismatch_cnt++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("last_cell expected %b got %b", want.last, m_axis_tlast);
            mismatch_cnt++;
          end
        end
      end
      cells_due_o <= cell_q.size();
    end
  end

endmodule

FILE: verif/periodic_neighbour_cell_enumerator_top_test.sv
// Testbench top for the periodic neighbour cell enumerator: clock, reset, config writes,
// position stimulus and the cell-side ready pattern. Needs pnce_pkg and pnce_cell_checker.
module periodic_neighbour_cell_enumerator_top_test;
  import pnce_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;    // pos_x, pos_y, pos_z
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;    // cell_index, wrap_x, wrap_y, wrap_z, pad
  logic                m_axis_tlast;    // last_cell
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  int cells_due;
  int mismatches;
  int positions_sent = 0;

  // steady = no idling on either side for the current phase
  bit          steady = 1'b0;
  int unsigned stall_left = 0;
  int unsigned roll;

  // stimulus-side copy of the grid, only used to aim positions at cell edges
  logic [CntW-1:0]  aim_cells [3];
  logic [SizeW-1:0] aim_size  [3];

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  periodic_neighbour_cell_enumerator_top dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  pnce_cell_checker u_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .cells_due_o  (cells_due),
    .mismatches_o (mismatches)
  );

  // Cell-side back-pressure: mostly ready, short stalls often, long ones rarely.
  // A long stall lets the front park positions in the queue and drop s_axis_tready.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (steady) begin
      m_axis_tready <= 1'b1;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 15) begin
        m_axis_tready <= 1'b0;
        stall_left    <= $urandom_range(0, 2);
      end else if (roll < 18) begin
        m_axis_tready <= 1'b0;
        stall_left    <= $urandom_range(10, 60);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Idle cycles before a position beat; none in steady phases.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Position beat. tvalid is only lowered when a gap follows, so back-to-back beats
  // keep it high without a second assignment in the same step.
  task automatic send_pos(logic [PosW-1:0] px, logic [PosW-1:0] py, logic [PosW-1:0] pz);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {pz, py, px};
    do @(posedge clk_i); while (!s_axis_tready);
    positions_sent++;
  endtask

  // Sender stops until every predicted cell beat has been taken.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (cells_due != 0);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Writes the whole register file; only called with the block drained.
  task automatic configure(bit per, logic [CntW-1:0] cx, logic [CntW-1:0] cy,
                           logic [CntW-1:0] cz, bit rad, logic [SizeW-1:0] sx,
                           logic [SizeW-1:0] sy, logic [SizeW-1:0] sz);
    write_reg(RegPeriodic, 32'(per));
    write_reg(RegCellsX, 32'(cx));
    write_reg(RegCellsY, 32'(cy));
    write_reg(RegCellsZ, 32'(cz));
    write_reg(RegRadius, 32'(rad));
    write_reg(RegSizeX, sx);
    write_reg(RegSizeY, sy);
    write_reg(RegSizeZ, sz);
    cfg_valid_i  <= 1'b0;
    aim_cells[0] = cx;
    aim_cells[1] = cy;
    aim_cells[2] = cz;
    aim_size[0]  = sx;
    aim_size[1]  = sy;
    aim_size[2]  = sz;
  endtask

  // Cell counts: degenerate, tiny, full and over-range grids besides ordinary ones.
  function automatic logic [CntW-1:0] pick_cells();
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r)
      0: return 0;
      1: return 1;
      2: return 2;
      3: return 256;
      4: return CntW'($urandom_range(257, 511));
      default: return CntW'($urandom_range(3, 24));
    endcase
  endfunction

  function automatic logic [SizeW-1:0] pick_size();
    int unsigned r;
    r = $urandom_range(0, 11);
    case (r)
      0: return '0;
      1: return '1;
      2: return 1;
      default: return $urandom_range(32'h0000_1000, 32'h0010_0000);
    endcase
  endfunction

  // Mostly a point inside a chosen cell (edges and one past the grid included),
  // otherwise a raw 32-bit value so every position bit toggles.
  function automatic logic [PosW-1:0] pick_pos(int a);
    logic [63:0] v;
    if ($urandom_range(0, 9) < 4 || aim_size[a] == 0) return $urandom();
    v = 64'($urandom_range(0, 32'(aim_cells[a]))) * 64'(aim_size[a])
      + 64'($urandom_range(0, aim_size[a] - 1));
    return (v > 64'hFFFF_FFFF) ? '1 : v[PosW-1:0];
  endfunction

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = RegPeriodic;
    cfg_data_i    = '0;
    aim_cells     = '{16, 16, 16};
    aim_size      = '{32'h0001_0000, 32'h0001_0000, 32'h0001_0000};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset values: periodic 16^3 grid, unit cells. Corners wrap low and high.
    send_pos(32'h0, 32'h0, 32'h0);
    send_pos('1, '1, '1);
    send_pos(32'h0005_8000, 32'h0007_4000, 32'h0009_0000);
    send_pos(32'h000F_FFFF, 32'h0, 32'h0008_0000);
    drain();

    // Open mode; x full 256-cell axis with size 1, y single cell, z zero cell size.
    configure(1'b0, 9'd256, 9'd1, 9'd2, 1'b1, 32'd1, '1, 32'd0);
    send_pos(32'h0, 32'h0, 32'h0);
    send_pos('1, '1, '1);
    send_pos(32'd255, 32'd12345, 32'd7);
    send_pos(32'd100, 32'h0, 32'h0);
    drain();

    // Periodic; zero cell count, two cells (repeats with both wraps), over-range count.
    configure(1'b1, 9'd0, 9'd2, 9'd511, 1'b1, 32'd0, 32'h0001_0000, 32'd1);
    send_pos(32'h0, 32'h0, 32'h0);
    send_pos('1, '1, '1);
    send_pos(32'd123, 32'h0001_0000, 32'd255);
    send_pos(32'h0, 32'h0001_8000, 32'd256);
    drain();

    // Radius zero: one cell per position in both modes.
    configure(1'b1, 9'd16, 9'd16, 9'd16, 1'b0, 32'h0001_0000, 32'h0001_0000,
              32'h0001_0000);
    send_pos(32'h0, 32'h0, 32'h0);
    send_pos('1, '1, '1);
    send_pos(32'h0008_0000, 32'h0003_0000, 32'h000E_FFFF);
    drain();
    configure(1'b0, 9'd3, 9'd3, 9'd3, 1'b0, 32'h0002_0000, 32'h0002_0000, 32'h0002_0000);
    send_pos(32'h0, 32'h0, 32'h0);
    send_pos(32'h0005_0000, 32'h0002_0000, 32'h0003_FFFF);
    drain();

    // Random phases: fresh register set each time, then a burst of positions.
    while (positions_sent < 220) begin
      steady <= ($urandom_range(0, 3) == 0);
      configure(bit'($urandom_range(0, 1)), pick_cells(), pick_cells(), pick_cells(),
                ($urandom_range(0, 4) != 0), pick_size(), pick_size(), pick_size());
      repeat ($urandom_range(10, 40)) send_pos(pick_pos(0), pick_pos(1), pick_pos(2));
      drain();
    end

    // Everything taken; leave room for a stray beat before the verdict.
    repeat (60) @(posedge clk_i);
    if (mismatches == 0)
      $display("periodic_neighbour_cell_enumerator_top verification clean");
    else
      $display("periodic_neighbour_cell_enumerator_top verification failed");
    $finish;
  end

  // Worst case: 27 beats per position, each behind a long stall; 10 ms covers it several
  // times over.
  initial begin
    #10_000_000;
    $display("periodic_neighbour_cell_enumerator_top verification failed");
    $finish;
  end

endmodule
